/* hw/rtl/sssd_pkg.sv */
// ----------------------------------------------------------------------------
// sssd_pkg: shared types and constants of the start-step-stop bit decoder
// Holds the field widths, the result record and the code tables that map a
// prefix length to its payload length and offset.
// ----------------------------------------------------------------------------
package sssd_pkg;

    localparam int unsigned VALUE_W   = 12;
    localparam int unsigned PAYLOAD_W = 11;
    localparam int unsigned ONES_W    = 3;
    localparam int unsigned INDEX_W   = 4;
    localparam int unsigned CODE_W    = 12;

    localparam logic [ONES_W-1:0] MAX_ONES = 3'd4;

    localparam logic signed [VALUE_W-1:0] STOP_RESET = 12'sd1362;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      eos;
    } t_result;

    function automatic logic [CODE_W-1:0] code_offset(input logic [ONES_W-1:0] ones);
        logic [CODE_W-1:0] off;
        case (ones)
            3'd0:    off = 12'd0;
            3'd1:    off = 12'd8;
            3'd2:    off = 12'd40;
            3'd3:    off = 12'd168;
            default: off = 12'd680;
        endcase
        return off;
    endfunction

    function automatic logic [INDEX_W-1:0] payload_len(input logic [ONES_W-1:0] ones);
        logic [INDEX_W-1:0] len;
        case (ones)
            3'd0:    len = 4'd3;
            3'd1:    len = 4'd5;
            3'd2:    len = 4'd7;
            3'd3:    len = 4'd9;
            default: len = 4'd11;
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/sssd_in_reg.sv */
// ----------------------------------------------------------------------------
// sssd_in_reg: input register
// Captures one code bit per transfer and holds it until the decode stage
// advances.
// ----------------------------------------------------------------------------
module sssd_in_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_bit,
    input  logic i_advance,
    output logic o_valid,
    output logic o_bit
);

    logic r_valid;
    logic r_bit;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_bit   = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bit <= i_bit;
        end
    end

endmodule

/* hw/rtl/sssd_decode.sv */
// ----------------------------------------------------------------------------
// sssd_decode: code state and value decode
// Tracks the prefix and payload of the current code word, and on the last
// payload bit forms the unmapped signed value and checks it against the stop
// value register.
// ----------------------------------------------------------------------------
module sssd_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic signed [sssd_pkg::VALUE_W-1:0] i_cfg_data,
    input  logic                                i_fire,
    input  logic                                i_bit,
    output sssd_pkg::t_result                   o_res
);

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    t_phase                                r_phase,   n_phase;
    logic [sssd_pkg::ONES_W-1:0]           r_ones,    n_ones;
    logic [sssd_pkg::INDEX_W-1:0]          r_index,   n_index;
    logic [sssd_pkg::PAYLOAD_W-1:0]        r_payload, n_payload;
    logic signed [sssd_pkg::VALUE_W-1:0]   r_stop;

    logic [sssd_pkg::PAYLOAD_W-1:0]        w_payload;
    logic [sssd_pkg::INDEX_W-1:0]          w_index;
    logic [sssd_pkg::CODE_W-1:0]           w_code;
    logic [sssd_pkg::VALUE_W-1:0]          w_half;
    logic signed [sssd_pkg::VALUE_W-1:0]   w_value;

    always_comb begin
        w_payload = r_payload;
        if (r_index < 4'(sssd_pkg::PAYLOAD_W)) begin
            w_payload = r_payload
                | (sssd_pkg::PAYLOAD_W'(i_bit) << r_index);
        end
        w_index = r_index + 4'd1;
        w_code  = sssd_pkg::CODE_W'(w_payload) + sssd_pkg::code_offset(r_ones);
        w_half  = {1'b0, w_code[sssd_pkg::CODE_W-1:1]};
        w_value = w_code[0] ? -$signed(w_half) : $signed(w_half);
    end

    always_comb begin
        n_phase   = r_phase;
        n_ones    = r_ones;
        n_index   = r_index;
        n_payload = r_payload;
        o_res     = '0;
        case (r_phase)
            PH_PREFIX: begin
                if (i_bit) begin
                    n_ones = r_ones + 3'd1;
                    if (r_ones + 3'd1 >= sssd_pkg::MAX_ONES) begin
                        n_ones    = sssd_pkg::MAX_ONES;
                        n_phase   = PH_PAYLOAD;
                        n_index   = '0;
                        n_payload = '0;
                    end
                end else begin
                    n_phase   = PH_PAYLOAD;
                    n_index   = '0;
                    n_payload = '0;
                end
            end
            PH_PAYLOAD: begin
                n_payload = w_payload;
                n_index   = w_index;
                if (w_index >= sssd_pkg::payload_len(r_ones)) begin
                    n_phase     = PH_PREFIX;
                    n_ones      = '0;
                    n_index     = '0;
                    n_payload   = '0;
                    o_res.valid = 1'b1;
                    if (w_value == r_stop) begin
                        n_phase   = PH_DONE;
                        o_res.eos = 1'b1;
                    end else begin
                        o_res.value = w_value;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (!i_fire) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PREFIX;
            r_ones    <= '0;
            r_index   <= '0;
            r_payload <= '0;
            r_stop    <= sssd_pkg::STOP_RESET;
        end else begin
            if (i_fire) begin
                r_phase   <= n_phase;
                r_ones    <= n_ones;
                r_index   <= n_index;
                r_payload <= n_payload;
            end
            if (i_cfg_valid) begin
                r_stop <= i_cfg_data;
            end
        end
    end

endmodule

/* hw/rtl/sssd_out_reg.sv */
// ----------------------------------------------------------------------------
// sssd_out_reg: result register
// Holds one decoded result until the downstream side takes it, and tells the
// decode stage when a new result can be loaded.
// ----------------------------------------------------------------------------
module sssd_out_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sssd_pkg::t_result                   i_res,
    output logic                                o_can_load,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [sssd_pkg::VALUE_W-1:0] o_value,
    output logic                                o_eos
);

    logic                                r_valid;
    logic signed [sssd_pkg::VALUE_W-1:0] r_value;
    logic                                r_eos;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_value    = r_value;
    assign o_eos      = r_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_res.valid) begin
            r_value <= i_res.value;
            r_eos   <= i_res.eos;
        end
    end

endmodule

/* hw/rtl/start_step_stop_bit_decoder.sv */
// ----------------------------------------------------------------------------
// start_step_stop_bit_decoder: start-step-stop (3,2,11) code decoder
// Decodes a bit-serial prefix code into signed values, code bit 0 as sign.
// ----------------------------------------------------------------------------
// The slave stream takes one code bit per transfer in s_axis_tdata[0]. Each
// code word is a prefix of up to four ones (ended by a zero when shorter),
// then 3 to 11 payload bits, least significant first. When the last payload
// bit of a word is taken, one result leaves on the master stream: the signed
// value in m_axis_tdata[11:0], with m_axis_tlast low. When the value equals
// the stop value, the result carries value 0 with m_axis_tlast high,
// and all later bits are taken and dropped until reset.
// The stop value is written through the config channel, which is always
// ready; write it only while no bits are in flight.
// Throughput is one bit per cycle while the result register is empty or its
// result is being taken. A word's last bit waits in the input register and
// is decoded into the result register when that register can load. When the
// receiver stalls, the result register holds its result and an empty input
// register still takes one more bit; the slave side then deasserts
// s_axis_tready until the result is taken.
// Reset clears the code state, empties both registers and sets the stop
// value back to 1362.
// ----------------------------------------------------------------------------
module start_step_stop_bit_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [0] code_bit
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // [11:0] value
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic signed [sssd_pkg::VALUE_W-1:0] i_cfg_data
);

    logic                                w_advance;
    logic                                w_in_valid;
    logic                                w_in_bit;
    sssd_pkg::t_result                   w_res;
    logic signed [sssd_pkg::VALUE_W-1:0] w_value;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {4'd0, w_value};

    sssd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_bit     (s_axis_tdata[0]),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_bit     (w_in_bit)
    );

    sssd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_in_valid && w_advance),
        .i_bit       (w_in_bit),
        .o_res       (w_res)
    );

    sssd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (w_res),
        .o_can_load (w_advance),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (w_value),
        .o_eos      (m_axis_tlast)
    );

endmodule
